// ----- rtl/line_follow_pid_steer_macros.svh -----
`ifndef LINE_FOLLOW_PID_STEER_MACROS_SVH
`define LINE_FOLLOW_PID_STEER_MACROS_SVH

// Overlapping implication, held off during reset.
`define LFPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked while reset is applied.
`define LFPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lfps_pkg.sv -----
package lfps_pkg;

  localparam int DRIVE_BITS = 10;
  localparam int GAIN_BITS  = 16;
  localparam int BASE_BITS  = 10;
  localparam int POS_BITS   = 4;
  localparam int DIFF_BITS  = POS_BITS + 1;
  localparam int INTEG_BITS = 16;
  localparam int PAT_BITS   = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int P_PROP_BITS  = GAIN_BITS + POS_BITS;
  localparam int P_INTEG_BITS = GAIN_BITS + INTEG_BITS;
  localparam int P_DERIV_BITS = GAIN_BITS + DIFF_BITS;
  localparam int PID_BITS     = P_INTEG_BITS + 1;
  localparam int SUM_BITS     = PID_BITS + 1;
  localparam int FRAC_BITS    = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_SPEED = 2'd3;

  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 16'd3328;
  localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST = 16'd307;
  localparam logic [BASE_BITS-1:0] BASE_SPEED_RST = 10'd270;

  localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = 16'sh7fff;
  localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = 16'sh8000;

  localparam logic [(1<<PAT_BITS)-1:0][POS_BITS-1:0] POS_TABLE = {
    4'sd0, 4'sd4, 4'sd0, 4'sd3, 4'sd0, 4'sd0, 4'sd0, 4'sd6,
    -4'sd4, 4'sd0, 4'sd0, 4'sd1, -4'sd3, -4'sd1, -4'sd6, 4'sd0
  };
  localparam logic [(1<<PAT_BITS)-1:0] POS_KNOWN = 16'b0101_0001_1101_1110;

  typedef struct packed {
    logic signed [POS_BITS-1:0]   pos;
    logic signed [INTEG_BITS-1:0] acc;
    logic signed [DIFF_BITS-1:0]  diff;
  } stage_a_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0]     pos;
    logic signed [P_PROP_BITS-1:0]  p_prop;
    logic signed [P_INTEG_BITS-1:0] p_integ;
    logic signed [P_DERIV_BITS-1:0] p_deriv;
  } stage_b_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] prop_gain;
    logic [GAIN_BITS-1:0] integ_gain;
    logic [GAIN_BITS-1:0] deriv_gain;
  } gains_t;

  // Q26.8 to integer drive: truncate toward zero, clamp to the drive range.
  function automatic logic [DRIVE_BITS-1:0] drive_sat(input logic signed [SUM_BITS-1:0] q);
    logic [SUM_BITS-FRAC_BITS-1:0] whole;
    logic [DRIVE_BITS-1:0]         res;
    whole = q[SUM_BITS-1:FRAC_BITS];
    if (q[SUM_BITS-1]) begin
      res = '0;
    end else if (whole > {{(SUM_BITS-FRAC_BITS-DRIVE_BITS){1'b0}}, {DRIVE_BITS{1'b1}}}) begin
      res = '1;
    end else begin
      res = whole[DRIVE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/lfps_front.sv -----
module lfps_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic [lfps_pkg::PAT_BITS-1:0]    pattern,
  input  logic                             down_ready,
  output logic                             a_valid,
  output lfps_pkg::stage_a_t               a_data
);

  logic                                     a_valid_r, a_valid_nxt;
  lfps_pkg::stage_a_t                       a_data_r;
  logic signed [lfps_pkg::POS_BITS-1:0]     held_position_r;
  logic signed [lfps_pkg::INTEG_BITS-1:0]   error_integral_r, error_integral_nxt;
  logic signed [lfps_pkg::POS_BITS-1:0]     pos;
  logic signed [lfps_pkg::INTEG_BITS:0]     acc_wide;
  logic signed [lfps_pkg::DIFF_BITS-1:0]    diff;
  logic                                     fire;

  assign up_ready = !a_valid_r || down_ready;
  assign fire     = up_valid && up_ready;

  always_comb begin
    pos = lfps_pkg::POS_KNOWN[pattern] ? lfps_pkg::POS_TABLE[pattern] : held_position_r;
    acc_wide = {error_integral_r[lfps_pkg::INTEG_BITS-1], error_integral_r}
             + {{(lfps_pkg::INTEG_BITS+1-lfps_pkg::POS_BITS){pos[lfps_pkg::POS_BITS-1]}}, pos};
    if (acc_wide > $signed({lfps_pkg::INTEG_MAX[lfps_pkg::INTEG_BITS-1], lfps_pkg::INTEG_MAX})) begin
      error_integral_nxt = lfps_pkg::INTEG_MAX;
    end else if (acc_wide < $signed({lfps_pkg::INTEG_MIN[lfps_pkg::INTEG_BITS-1],
                                     lfps_pkg::INTEG_MIN})) begin
      error_integral_nxt = lfps_pkg::INTEG_MIN;
    end else begin
      error_integral_nxt = acc_wide[lfps_pkg::INTEG_BITS-1:0];
    end
    diff = {pos[lfps_pkg::POS_BITS-1], pos}
         - {held_position_r[lfps_pkg::POS_BITS-1], held_position_r};
    if (fire) begin
      a_valid_nxt = 1'b1;
    end else if (down_ready) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r        <= 1'b0;
      held_position_r  <= '0;
      error_integral_r <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (fire) begin
        held_position_r  <= pos;
        error_integral_r <= error_integral_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_data_r.pos  <= pos;
      a_data_r.acc  <= error_integral_nxt;
      a_data_r.diff <= diff;
    end
  end

  assign a_valid = a_valid_r;
  assign a_data  = a_data_r;

endmodule

// ----- rtl/lfps_mult.sv -----
module lfps_mult (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfps_pkg::gains_t     gains,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  lfps_pkg::stage_a_t   a_data,
  input  logic                 down_ready,
  output logic                 b_valid,
  output lfps_pkg::stage_b_t   b_data
);

  logic               b_valid_r;
  lfps_pkg::stage_b_t b_data_r, b_data_nxt;
  logic               fire;

  assign up_ready = !b_valid_r || down_ready;
  assign fire     = up_valid && up_ready;

  always_comb begin
    b_data_nxt.pos     = a_data.pos;
    b_data_nxt.p_prop  = $signed(gains.prop_gain) * a_data.pos;
    b_data_nxt.p_integ = $signed(gains.integ_gain) * a_data.acc;
    b_data_nxt.p_deriv = $signed(gains.deriv_gain) * a_data.diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (fire) begin
      b_valid_r <= 1'b1;
    end else if (down_ready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign b_valid = b_valid_r;
  assign b_data  = b_data_r;

endmodule

// ----- rtl/lfps_drive.sv -----
module lfps_drive (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lfps_pkg::BASE_BITS-1:0]       base_speed,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  lfps_pkg::stage_b_t                   b_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [lfps_pkg::DRIVE_BITS-1:0]      left_drive,
  output logic [lfps_pkg::DRIVE_BITS-1:0]      right_drive,
  output logic signed [lfps_pkg::POS_BITS-1:0] line_position
);

  logic                                     out_valid_r;
  logic [lfps_pkg::DRIVE_BITS-1:0]          left_r, right_r;
  logic signed [lfps_pkg::POS_BITS-1:0]     pos_r;
  logic signed [lfps_pkg::PID_BITS-1:0]     pid;
  logic signed [lfps_pkg::SUM_BITS-1:0]     base_q, sum_l, sum_r;
  logic                                     fire;

  assign up_ready = !out_valid_r || !out_stall;
  assign fire     = up_valid && up_ready;

  always_comb begin
    pid = {{(lfps_pkg::PID_BITS-lfps_pkg::P_PROP_BITS){b_data.p_prop[lfps_pkg::P_PROP_BITS-1]}},
           b_data.p_prop}
        + {{(lfps_pkg::PID_BITS-lfps_pkg::P_INTEG_BITS){b_data.p_integ[lfps_pkg::P_INTEG_BITS-1]}},
           b_data.p_integ}
        + {{(lfps_pkg::PID_BITS-lfps_pkg::P_DERIV_BITS){b_data.p_deriv[lfps_pkg::P_DERIV_BITS-1]}},
           b_data.p_deriv};
    base_q = {{(lfps_pkg::SUM_BITS-lfps_pkg::BASE_BITS-lfps_pkg::FRAC_BITS){1'b0}},
              base_speed, {lfps_pkg::FRAC_BITS{1'b0}}};
    sum_l  = base_q + {pid[lfps_pkg::PID_BITS-1], pid};
    sum_r  = base_q - {pid[lfps_pkg::PID_BITS-1], pid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left_r  <= lfps_pkg::drive_sat(sum_l);
      right_r <= lfps_pkg::drive_sat(sum_r);
      pos_r   <= b_data.pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign left_drive    = left_r;
  assign right_drive   = right_r;
  assign line_position = pos_r;

endmodule

// ----- rtl/line_follow_pid_steer.sv -----
// PID steering for a four-sensor line follower.
// Input channel: in_valid / in_stall carry one in_sensor_pattern per
// transaction. The pattern is decoded to a line position (-6..6); an
// unrecognized pattern keeps the last position. The position feeds a
// saturating 16-bit integral and a Q25.8 PID correction.
// Output channel: out_valid / out_stall carry left and right drive
// (base_speed +/- correction, truncated and clamped to the drive range)
// and the position used.
// Path: an input transaction passes the decode/integral register, the
// product register and the drive register, in that order, before
// out_valid rises. Throughput: one transaction per cycle while out_stall
// is low; each stage is a single pass through one register.
// Stall: out_stall backs up through the stage registers; in_stall rises
// only when every stage holds a transaction that cannot move.
// Config: cfg_we writes cfg_data into register cfg_index (0 prop_gain,
// 1 integ_gain, 2 deriv_gain, 3 base_speed); write only while idle.
// Reset: gains and base speed return to defaults, position and integral
// clear, all stages empty.
module line_follow_pid_steer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lfps_pkg::PAT_BITS-1:0]        in_sensor_pattern,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lfps_pkg::DRIVE_BITS-1:0]      out_left_drive,
  output logic [lfps_pkg::DRIVE_BITS-1:0]      out_right_drive,
  output logic signed [lfps_pkg::POS_BITS-1:0] out_line_position,
  input  logic                                 cfg_we,
  input  logic [lfps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lfps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  lfps_pkg::gains_t                  gains_r;
  logic [lfps_pkg::BASE_BITS-1:0]    base_speed_r;
  logic                              front_ready, a_valid, mult_ready, b_valid, drive_ready;
  lfps_pkg::stage_a_t                a_data;
  lfps_pkg::stage_b_t                b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.prop_gain  <= lfps_pkg::PROP_GAIN_RST;
      gains_r.integ_gain <= lfps_pkg::INTEG_GAIN_RST;
      gains_r.deriv_gain <= lfps_pkg::DERIV_GAIN_RST;
      base_speed_r       <= lfps_pkg::BASE_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lfps_pkg::REG_PROP_GAIN:  gains_r.prop_gain  <= cfg_data;
        lfps_pkg::REG_INTEG_GAIN: gains_r.integ_gain <= cfg_data;
        lfps_pkg::REG_DERIV_GAIN: gains_r.deriv_gain <= cfg_data;
        lfps_pkg::REG_BASE_SPEED: base_speed_r       <= cfg_data[lfps_pkg::BASE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !front_ready;

  lfps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (front_ready),
    .pattern    (in_sensor_pattern),
    .down_ready (mult_ready),
    .a_valid    (a_valid),
    .a_data     (a_data)
  );

  lfps_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .up_valid   (a_valid),
    .up_ready   (mult_ready),
    .a_data     (a_data),
    .down_ready (drive_ready),
    .b_valid    (b_valid),
    .b_data     (b_data)
  );

  lfps_drive u_drive (
    .clk           (clk),
    .rst_n         (rst_n),
    .base_speed    (base_speed_r),
    .up_valid      (b_valid),
    .up_ready      (drive_ready),
    .b_data        (b_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .left_drive    (out_left_drive),
    .right_drive   (out_right_drive),
    .line_position (out_line_position)
  );

endmodule

// ----- rtl/lfps_checker.sv -----
`include "line_follow_pid_steer_macros.svh"

module lfps_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [lfps_pkg::DRIVE_BITS-1:0]      out_left_drive,
  input logic [lfps_pkg::DRIVE_BITS-1:0]      out_right_drive,
  input logic signed [lfps_pkg::POS_BITS-1:0] out_line_position
);

  `LFPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_left_drive) && $stable(out_right_drive)
      && $stable(out_line_position), "stalled result changed")

  `LFPS_ASSERT_NOW(a_pos_range, clk, rst_n, out_valid,
    out_line_position >= -4'sd6 && out_line_position <= 4'sd6, "position out of range")

  `LFPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid,
    "result valid right after reset")

  `LFPS_ASSERT_NEXT(a_latency, clk, rst_n,
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid,
    "accepted transaction did not reach the output")

endmodule

bind line_follow_pid_steer lfps_checker u_lfps_checker (.*);
